FILE: rtl/sstf_pkg.sv
`default_nettype none

package sstf_pkg;

    localparam int CYL_BITS  = 12;
    localparam int COST_BITS = 16;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    typedef struct packed {
        logic [CYL_BITS-1:0] request_cylinder;
        logic                batch_end;
    } t_in_item;

    typedef struct packed {
        logic [CYL_BITS-1:0]  served_cylinder;
        logic [CYL_BITS-1:0]  seek_distance;
        logic [COST_BITS-1:0] total_cost;
        logic                 last_service;
        logic                 overflow;
    } t_out_item;

    // Contents of one cell of the request row.
    typedef struct packed {
        logic [CYL_BITS-1:0] cyl;
        logic                valid;
        logic                served;
    } t_cell_data;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic clear;
        logic shift;
        logic mark;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SWEEP,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sstf_cell.sv
`default_nettype none

module sstf_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sstf_pkg::t_cell_ctrl i_ctrl,
    input  sstf_pkg::t_cell_data i_prev,
    output sstf_pkg::t_cell_data o_data
);

    logic [sstf_pkg::CYL_BITS-1:0] r_cyl;
    logic                          r_valid;
    logic                          r_served;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_served <= 1'b0;
        end else begin
            priority if (i_ctrl.clear) begin
                r_valid  <= 1'b0;
                r_served <= 1'b0;
            end else if (i_ctrl.shift) begin
                r_valid  <= i_prev.valid;
                r_served <= i_prev.served;
            end else if (i_ctrl.mark) begin
                r_served <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_cyl <= i_prev.cyl;
        end
    end

    assign o_data.cyl    = r_cyl;
    assign o_data.valid  = r_valid;
    assign o_data.served = r_served;

endmodule

`default_nettype wire

FILE: rtl/sstf_disk_scheduler_top.sv
// Requests load at one item per cycle into a row of MAX_REQUESTS cells.
// After the batch-end item, each service rotates the row once past a single distance
// comparator, then writes the result once the output register is free.
// A batch of n stored requests thus yields n results, one per service.
// Synchronous active-low reset empties the row, clears all counters and sets the
// start position to zero; the block is ready to load right after reset.
`default_nettype none

module sstf_disk_scheduler_top #(
    parameter int MAX_REQUESTS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  sstf_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output sstf_pkg::t_out_item             o_out_item,
    input  wire                             i_cfg_we,
    input  wire [sstf_pkg::CYL_BITS-1:0]    i_cfg_wdata
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int SW = $clog2(MAX_REQUESTS);
    localparam int CB = sstf_pkg::CYL_BITS;
    localparam int KB = sstf_pkg::COST_BITS;

    sstf_pkg::t_state     r_state, n_state;
    logic [CB-1:0]        r_start;
    logic [CB-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_done, n_done;
    logic [KB-1:0]        r_cost, n_cost;
    logic                 r_dropped, n_dropped;
    logic [SW-1:0]        r_step, n_step;
    logic                 r_found, n_found;
    logic [CB-1:0]        r_best_d, n_best_d;
    logic [CB-1:0]        r_best_cyl, n_best_cyl;
    logic [SW-1:0]        r_best_pos, n_best_pos;
    logic                 r_out_valid, n_out_valid;
    sstf_pkg::t_out_item  r_out_item, n_out_item;

    sstf_pkg::t_cell_data w_cell [MAX_REQUESTS];
    sstf_pkg::t_cell_data w_feed;
    sstf_pkg::t_cell_data w_tail;

    logic          in_fire;
    logic          store_en;
    logic          sweep_en;
    logic          out_free;
    logic          emit_fire;
    logic          emit_last;
    logic [CW-1:0] done_inc;
    logic [CB-1:0] seek_dist;
    logic          cand;
    logic [KB:0]   cost_sum;

    assign w_tail    = w_cell[MAX_REQUESTS-1];
    assign in_fire   = i_in_valid && o_in_ready;
    assign store_en  = in_fire && (r_count < CW'(MAX_REQUESTS));
    assign sweep_en  = (r_state == sstf_pkg::S_SWEEP);
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_fire = (r_state == sstf_pkg::S_EMIT) && out_free;
    assign done_inc  = r_done + CW'(1);
    assign emit_last = (done_inc == r_count);

    // The row is fed from the input while loading and from its own tail while sweeping,
    // so a full rotation presents entries at the tail oldest first.
    always_comb begin
        if (r_state == sstf_pkg::S_LOAD) begin
            w_feed.cyl    = i_in_item.request_cylinder;
            w_feed.valid  = 1'b1;
            w_feed.served = 1'b0;
        end else begin
            w_feed = w_tail;
        end
    end

    for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
        sstf_pkg::t_cell_ctrl c_ctrl;
        always_comb begin
            c_ctrl.clear = emit_fire && emit_last;
            c_ctrl.shift = store_en || sweep_en;
            c_ctrl.mark  = emit_fire && (r_best_pos == SW'(MAX_REQUESTS - 1 - i));
        end
        sstf_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (c_ctrl),
            .i_prev ((i == 0) ? w_feed : w_cell[(i == 0) ? 0 : i - 1]),
            .o_data (w_cell[i])
        );
    end

    assign seek_dist = (w_tail.cyl > r_head) ? (w_tail.cyl - r_head) : (r_head - w_tail.cyl);
    assign cand      = w_tail.valid && !w_tail.served;
    assign cost_sum  = {1'b0, r_cost} + (KB + 1)'(r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sstf_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_done      = r_done;
        n_cost      = r_cost;
        n_dropped   = r_dropped;
        n_step      = r_step;
        n_found     = r_found;
        n_best_d    = r_best_d;
        n_best_cyl  = r_best_cyl;
        n_best_pos  = r_best_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        o_in_ready  = 1'b0;

        unique case (r_state)
            sstf_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (store_en) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_item.batch_end) begin
                        n_head  = r_start;
                        n_cost  = '0;
                        n_done  = '0;
                        n_step  = '0;
                        n_found = 1'b0;
                        n_state = sstf_pkg::S_SWEEP;
                    end
                end
            end
            sstf_pkg::S_SWEEP: begin
                // Strict less-than keeps the earliest loaded request on a tie.
                if (cand && (!r_found || seek_dist < r_best_d)) begin
                    n_found    = 1'b1;
                    n_best_d   = seek_dist;
                    n_best_cyl = w_tail.cyl;
                    n_best_pos = r_step;
                end
                n_step = r_step + SW'(1);
                if (r_step == SW'(MAX_REQUESTS - 1)) begin
                    n_state = sstf_pkg::S_EMIT;
                end
            end
            sstf_pkg::S_EMIT: begin
                if (emit_fire) begin
                    n_cost = cost_sum[KB] ? sstf_pkg::COST_MAX : cost_sum[KB-1:0];
                    n_out_valid                = 1'b1;
                    n_out_item.served_cylinder = r_best_cyl;
                    n_out_item.seek_distance   = r_best_d;
                    n_out_item.total_cost      = n_cost;
                    n_out_item.last_service    = emit_last;
                    n_out_item.overflow        = r_dropped;
                    n_head  = r_best_cyl;
                    n_done  = done_inc;
                    n_step  = '0;
                    n_found = 1'b0;
                    if (emit_last) begin
                        n_count   = '0;
                        n_done    = '0;
                        n_cost    = '0;
                        n_dropped = 1'b0;
                        n_state   = sstf_pkg::S_LOAD;
                    end else begin
                        n_state = sstf_pkg::S_SWEEP;
                    end
                end
            end
            default: begin
                n_state = sstf_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_done      <= '0;
            r_cost      <= '0;
            r_dropped   <= 1'b0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            r_head      <= n_head;
            r_count     <= n_count;
            r_done      <= n_done;
            r_cost      <= n_cost;
            r_dropped   <= n_dropped;
            r_step      <= n_step;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_d   <= n_best_d;
        r_best_cyl <= n_best_cyl;
        r_best_pos <= n_best_pos;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A completed sweep always finds an unserved request.
    a_found_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sstf_pkg::S_EMIT) |-> r_found)
        else $error("sweep ended without a candidate");

    // Services never outnumber stored requests.
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done < r_count) || (r_count == '0))
        else $error("service count out of range");

    // The final service empties the row and the counters.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && emit_last) |=> (r_count == '0) && !r_dropped && !w_tail.valid)
        else $error("batch state not cleared after final service");

    // A batch-end item stops loading until its services are done.
    a_batch_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.batch_end) |=> !o_in_ready && (r_count != '0))
        else $error("batch did not start scheduling");

endmodule

`default_nettype wire
